[rtl/core/fhc_pkg.sv]
// fhc_pkg: shared types, constants and the crc-32c byte update for the
// frame header checker; no dependencies
package fhc_pkg;

   localparam int HEADER_BYTES = 32;
   localparam int CRC_END      = 28;
   localparam int COUNT_W      = $clog2(HEADER_BYTES);
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;
   localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_MAGIC      = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FORMAT_VERSION   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAYLOAD_CAPACITY = 2'd2;

   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_BAD_MAGIC   = 3'd1;
   localparam logic [2:0] STATUS_BAD_VERSION = 3'd2;
   localparam logic [2:0] STATUS_CRC_ERROR   = 3'd3;
   localparam logic [2:0] STATUS_BAD_LENGTHS = 3'd4;

   localparam int RSP_DATA_W = 200;

   typedef struct packed {
      logic [31:0] frame_magic;
      logic [15:0] format_version;
      logic [31:0] payload_capacity;
   } cfg_type;

   // one complete header as captured by the front end
   typedef struct packed {
      logic [31:0] magic;
      logic [15:0] version;
      logic [15:0] flags;
      logic [31:0] frame_number;
      logic [31:0] frame_total;
      logic [31:0] payload_len;
      logic [31:0] plain_len;
      logic [31:0] payload_crc;
      logic [31:0] header_crc;
      logic [31:0] calc_crc;
   } record_type;

   typedef struct packed {
      logic        full;
      logic        empty;
   } queue_status_type;

   function automatic logic [31:0] crc32c_byte(input logic [31:0] crc,
                                               input logic [7:0]  data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[rtl/core/frame_header_checker_top.sv]
// frame_header_checker_top: checks 32-byte frame headers arriving one byte per word
// throughput: one byte per cycle while the queue is not full, one result per 32 bytes; set by the byte-wide crc update
// reset: synchronous; clears byte count, queue and output valid, sets crc to its initial value, loads register defaults
// depends on fhc_pkg, fhc_front, fhc_queue, fhc_back
module frame_header_checker_top #(
   parameter int QUEUE_DEPTH = fhc_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // header_byte
   input  logic                            req_tuser,   // first_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status, version, flags, frame_number, frame_total, payload_len, plain_len,
   // payload_crc, zero fill
   output logic [fhc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_we,
   input  logic [fhc_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [fhc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   fhc_pkg::cfg_type          cfg_ff;
   fhc_pkg::record_type       push_data, head_data;
   fhc_pkg::queue_status_type q_stat;
   logic                      q_push, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_magic      <= '0;
         cfg_ff.format_version   <= 16'd1;
         cfg_ff.payload_capacity <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            fhc_pkg::CSR_FRAME_MAGIC:      cfg_ff.frame_magic      <= csr_wdata;
            fhc_pkg::CSR_FORMAT_VERSION:   cfg_ff.format_version   <= csr_wdata[15:0];
            fhc_pkg::CSR_PAYLOAD_CAPACITY: cfg_ff.payload_capacity <= csr_wdata;
            default: ;
         endcase
      end
   end

   fhc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_stat.full),
      .q_push     (q_push),
      .q_data     (push_data)
   );

   fhc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (push_data),
      .pop     (q_pop),
      .rd_data (head_data),
      .stat    (q_stat)
   );

   fhc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_stat     (q_stat),
      .q_data     (head_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef ASSERT_OFF
   a_push_on_word: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (req_tvalid && req_tready))
      else $error("record pushed without a word");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("pop from empty queue");
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !req_tready)
      else $error("input ready while queue full");
`endif

endmodule

[rtl/core/fhc_front.sv]
// fhc_front: byte counter, crc-32c accumulator and header byte capture;
// pushes one record per complete header. depends on fhc_pkg
module fhc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tuser,
   input  logic                q_full,
   output logic                q_push,
   output fhc_pkg::record_type q_data
);

   localparam int NB = fhc_pkg::HEADER_BYTES;
   localparam int CW = fhc_pkg::COUNT_W;

   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   crc_ff, crc_in;
   logic [7:0]    hdr_ff [NB];
   logic [7:0]    cur [NB];
   logic [CW-1:0] idx;
   logic [31:0]   crc_base;
   logic          accept;
   logic          last;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign idx        = req_tuser ? '0 : count_ff;
   assign last       = (idx == CW'(NB - 1));
   assign crc_base   = req_tuser ? fhc_pkg::CRC_INIT : crc_ff;
   assign q_push     = accept && last;

   always_comb begin
      count_in = count_ff;
      crc_in   = crc_ff;
      if (accept) begin
         if (last) begin
            count_in = '0;
            crc_in   = fhc_pkg::CRC_INIT;
         end else begin
            count_in = idx + CW'(1);
            crc_in   = (idx < CW'(fhc_pkg::CRC_END)) ?
                       fhc_pkg::crc32c_byte(crc_base, req_tdata) : crc_base;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         crc_ff   <= fhc_pkg::CRC_INIT;
      end else begin
         count_ff <= count_in;
         crc_ff   <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hdr_ff[idx] <= req_tdata;
      end
   end

   // last byte comes straight from the input word
   always_comb begin
      for (int i = 0; i < NB; i++) begin
         cur[i] = hdr_ff[i];
      end
      cur[NB-1] = req_tdata;
   end

   always_comb begin
      q_data.magic        = {cur[3], cur[2], cur[1], cur[0]};
      q_data.version      = {cur[5], cur[4]};
      q_data.flags        = {cur[7], cur[6]};
      q_data.frame_number = {cur[11], cur[10], cur[9], cur[8]};
      q_data.frame_total  = {cur[15], cur[14], cur[13], cur[12]};
      q_data.payload_len  = {cur[19], cur[18], cur[17], cur[16]};
      q_data.plain_len    = {cur[23], cur[22], cur[21], cur[20]};
      q_data.payload_crc  = {cur[27], cur[26], cur[25], cur[24]};
      q_data.header_crc   = {cur[31], cur[30], cur[29], cur[28]};
      q_data.calc_crc     = crc_ff ^ fhc_pkg::CRC_INIT;
   end

`ifndef ASSERT_OFF
   a_count_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser && !last) |=> (count_ff == CW'(1)))
      else $error("count did not restart on first byte");
   a_wrap: assert property (@(posedge clock) disable iff (reset)
      q_push |=> (count_ff == '0 && crc_ff == fhc_pkg::CRC_INIT))
      else $error("count or crc not reset after last byte");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff) && $stable(crc_ff))
      else $error("state moved without a word");
`endif

endmodule

[rtl/core/fhc_queue.sv]
// fhc_queue: short register queue of header records between front and back
// depends on fhc_pkg
module fhc_queue #(
   parameter int DEPTH = fhc_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  fhc_pkg::record_type       wr_data,
   input  logic                      pop,
   output fhc_pkg::record_type       rd_data,
   output fhc_pkg::queue_status_type stat
);

   localparam int PW = $clog2(DEPTH);
   localparam int NW = $clog2(DEPTH + 1);

   fhc_pkg::record_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign stat.full  = (count_ff == NW'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign rd_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(DEPTH))
      else $error("queue count over depth");
   a_ptr_agree: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == NW'(DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && stat.full))
      else $error("push into full queue");
`endif

endmodule

[rtl/core/fhc_back.sv]
// fhc_back: header checks in priority order and the result output register
// depends on fhc_pkg
module fhc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  fhc_pkg::cfg_type          cfg,
   input  fhc_pkg::queue_status_type q_stat,
   input  fhc_pkg::record_type       q_data,
   output logic                      q_pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [fhc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic                       valid_ff, valid_in;
   logic [2:0]                 status_ff, status_in;
   fhc_pkg::record_type        rec_ff;

   assign q_pop = !q_stat.empty && (!valid_ff || rsp_tready);

   always_comb begin
      if (q_data.magic != cfg.frame_magic) begin
         status_in = fhc_pkg::STATUS_BAD_MAGIC;
      end else if (q_data.version != cfg.format_version) begin
         status_in = fhc_pkg::STATUS_BAD_VERSION;
      end else if (q_data.header_crc != q_data.calc_crc) begin
         status_in = fhc_pkg::STATUS_CRC_ERROR;
      end else if (q_data.payload_len > cfg.payload_capacity ||
                   q_data.plain_len > cfg.payload_capacity) begin
         status_in = fhc_pkg::STATUS_BAD_LENGTHS;
      end else begin
         status_in = fhc_pkg::STATUS_OK;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (q_pop) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         status_ff <= status_in;
         rec_ff    <= q_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, rec_ff.payload_crc, rec_ff.plain_len,
                        rec_ff.payload_len, rec_ff.frame_total,
                        rec_ff.frame_number, rec_ff.flags, rec_ff.version,
                        status_ff};

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_tready) |-> !q_pop)
      else $error("pending result overwritten");
   a_pop_fills: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> valid_ff)
      else $error("popped record not shown");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> status_ff <= fhc_pkg::STATUS_BAD_LENGTHS)
      else $error("status code out of range");
`endif

endmodule
